FILE: sv/crbf_pkg.sv
package crbf_pkg;

    // Table depth and the widths that follow from it
    localparam int MAX_CENTERS = 64;
    localparam int AW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CW = $clog2(MAX_CENTERS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_CENTERS = 1'b0,
        CFG_MIRROR_Y       = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    // Accumulator limits, Q16.16 in 48 bits
    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    // Register reset values
    localparam logic [6:0] ACTIVE_RESET = 7'd32;
    localparam logic       MIRROR_RESET = 1'b1;

    // Square root: one result bit per step over a 34-bit radicand
    localparam int SQRT_STEPS = 17;

endpackage

FILE: sv/crbf_req_if.sv
interface crbf_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [5:0]         entry_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] weight;
    logic signed [31:0] base_height;
    logic               last_query;

    modport source (
        output valid, req_type, entry_index, pos_x, pos_y, weight, base_height,
               last_query,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, pos_x, pos_y, weight, base_height,
               last_query,
        output ready
    );
endinterface

FILE: sv/crbf_res_if.sv
interface crbf_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] height;
    logic               saturated;
    logic               last_point;

    modport source (
        output valid, height, saturated, last_point,
        input  ready
    );
    modport sink (
        input  valid, height, saturated, last_point,
        output ready
    );
endinterface

FILE: sv/cubic_rbf_surface_evaluator_unit.sv
// Cubic RBF surface evaluator.
// i_req (valid/ready) carries load and query transactions. A load writes one
// center (x, y, weight) into the table and gives no result. A query sums
// weight * d^3 over the first active_centers entries on top of base_height
// and gives one transaction on o_res.
// Each center runs through one shared multiplier and a bit-serial square
// root: read, difference, dx^2, dy^2, 17 root steps, cube, weight, add.
// A query repeats these steps for each of N = active centers (at most
// 64) and returns to idle after the result is taken. i_req.ready is low
// for the whole query.
// The result stays in the output register while o_res.ready is low; no new
// transaction is taken until it leaves.
// Configuration (i_cfg_we/i_cfg_idx/i_cfg_data) is to be written by the user
// only while idle (the block does not enforce it): index 0 active_centers, index 1 mirror_y.
// Reset (synchronous, active low) returns to idle with active_centers = 32
// and mirror_y = 1. The center table is not cleared: query only entries
// that were loaded.
module cubic_rbf_surface_evaluator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crbf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [crbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    crbf_req_if.sink                       i_req,
    crbf_res_if.source                     o_res
);
    import crbf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_DIFF, ST_MXX, ST_MYY, ST_SQRT, ST_CUBE, ST_TERM,
        ST_ACC, ST_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [6:0] r_active;
    logic       r_mirror;

    // Query context
    logic signed [16:0] r_qx;
    logic signed [16:0] r_qy;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_idx;
    logic               r_last;

    // Datapath registers
    logic signed [17:0] r_dx;
    logic signed [17:0] r_dy;
    logic signed [31:0] r_w;
    logic [33:0]        r_r2;
    logic [33:0]        r_sq_src;
    logic [19:0]        r_sq_rem;
    logic [16:0]        r_sq_root;
    logic [4:0]         r_sq_cnt;
    logic [30:0]        r_phi;
    logic signed [46:0] r_term;
    logic signed [47:0] r_acc;
    logic               r_sat;

    // Center table, one word per entry: {x, y, weight}
    logic [63:0] r_mem [MAX_CENTERS];
    logic [63:0] r_rd;

    logic w_acc_in;
    assign w_acc_in = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_req.req_type == REQ_LOAD &&
            int'(i_req.entry_index) < MAX_CENTERS) begin
            r_mem[AW'(i_req.entry_index)] <= {i_req.pos_x, i_req.pos_y, i_req.weight};
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Shared multiplier, operands chosen by state
    logic signed [34:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [67:0] w_prod;

    always_comb begin
        case (r_state)
            ST_MXX: begin
                w_ma = 35'(r_dx);
                w_mb = 33'(r_dx);
            end
            ST_MYY: begin
                w_ma = 35'(r_dy);
                w_mb = 33'(r_dy);
            end
            ST_CUBE: begin
                w_ma = signed'({1'b0, r_r2});
                w_mb = signed'({16'd0, r_sq_root});
            end
            ST_TERM: begin
                w_ma = 35'(r_w);
                w_mb = signed'({2'b00, r_phi});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // Square root step: bring in two bits, try subtracting 4*root+1
    logic [19:0] w_rem_sh;
    logic [19:0] w_trial;
    logic        w_fit;
    assign w_rem_sh = {r_sq_rem[17:0], r_sq_src[33:32]};
    assign w_trial  = {1'b0, r_sq_root, 2'b01};
    assign w_fit    = w_rem_sh >= w_trial;

    // Accumulate with clamp to 48 bits
    logic signed [49:0] w_sum;
    logic               w_ovf;
    assign w_sum = 50'(r_acc) + 50'(r_term);
    assign w_ovf = !(w_sum[49] == w_sum[48] && w_sum[48] == w_sum[47]);

    // Query point with optional y mirror, and clamped active count
    logic signed [16:0] w_py;
    logic [CW-1:0]      w_n;
    assign w_py = (r_mirror && i_req.pos_y[15]) ? -17'(i_req.pos_y) : 17'(i_req.pos_y);
    assign w_n  = (int'(r_active) > MAX_CENTERS) ? CW'(MAX_CENTERS) : CW'(r_active);

    logic [33:0] w_r2_sum;
    assign w_r2_sum = r_r2 + w_prod[33:0];

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= ACTIVE_RESET;
            r_mirror    <= MIRROR_RESET;
            i_req.ready <= 1'b0;
            o_res.valid <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_ACTIVE_CENTERS: r_active <= i_cfg_data;
                    CFG_MIRROR_Y:       r_mirror <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_in && i_req.req_type == REQ_QUERY) begin
                        i_req.ready <= 1'b0;
                        r_qx   <= 17'(i_req.pos_x);
                        r_qy   <= w_py;
                        r_acc  <= 48'(i_req.base_height);
                        r_sat  <= 1'b0;
                        r_last <= i_req.last_query;
                        r_n    <= w_n;
                        r_idx  <= '0;
                        r_state <= (w_n == '0) ? ST_OUT : ST_RD;
                    end else begin
                        i_req.ready <= 1'b1;
                    end
                end
                ST_RD:   r_state <= ST_DIFF;
                ST_DIFF: begin
                    r_dx <= 18'(r_qx) - 18'(signed'(r_rd[63:48]));
                    r_dy <= 18'(r_qy) - 18'(signed'(r_rd[47:32]));
                    r_w  <= signed'(r_rd[31:0]);
                    r_state <= ST_MXX;
                end
                ST_MXX: begin
                    r_r2 <= w_prod[33:0];
                    r_state <= ST_MYY;
                end
                ST_MYY: begin
                    r_r2      <= w_r2_sum;
                    r_sq_src  <= w_r2_sum;
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_sq_cnt  <= 5'(SQRT_STEPS - 1);
                    r_state   <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_sq_src  <= {r_sq_src[31:0], 2'b00};
                    r_sq_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                    r_sq_root <= {r_sq_root[15:0], w_fit};
                    r_sq_cnt  <= r_sq_cnt - 5'd1;
                    if (r_sq_cnt == '0) r_state <= ST_CUBE;
                end
                ST_CUBE: begin
                    r_phi <= w_prod[50:20];
                    r_state <= ST_TERM;
                end
                ST_TERM: begin
                    r_term <= w_prod[62:16];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (w_ovf) begin
                        r_acc <= w_sum[49] ? ACC_MIN : ACC_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= w_sum[47:0];
                    end
                    r_idx <= r_idx + CW'(1);
                    r_state <= (r_idx + CW'(1) == r_n) ? ST_OUT : ST_RD;
                end
                ST_OUT: begin
                    if (o_res.valid && o_res.ready) begin
                        o_res.valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end else begin
                        o_res.valid      <= 1'b1;
                        o_res.height     <= r_acc;
                        o_res.saturated  <= r_sat;
                        o_res.last_point <= r_last;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Checks
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready)
        else $error("input taken while a result is pending");

    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_req.req_type == REQ_QUERY) |=> !i_req.ready)
        else $error("ready stayed high after a query");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_ACC) |-> (r_idx < r_n))
        else $error("center index beyond active count");

endmodule
